// ===== rtl/base64_encoder_top_defines.svh =====
// Assertion helpers shared by the encoder RTL.
`ifndef BASE64_ENCODER_TOP_DEFINES_SVH
`define BASE64_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b64e_pkg.sv =====
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  n_pad;
        logic        fin;
    } t_group;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h47 + {1'b0, v};
        end else if (v < 6'd62) begin
            c = {1'b0, v} - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage

// ===== rtl/b64e_if.sv =====
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== rtl/base64_encoder_top.sv =====
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel i_in: one raw byte per transfer, end_of_message marks the
// final byte of a message. Output channel o_out: one ASCII character per
// transfer, last_char set on the final character of the message.
// Every third byte, or any byte with end_of_message, closes a group that
// yields four characters; a short final group is zero-filled and padded
// with one or two '='.
// The first character of a group passes through the group queue and then the
// output register before it is offered.
// Throughput: one byte per cycle into the group queue while it has room, one
// character per cycle out of the output register while the receiver is ready;
// sustained, the pace is set by the single character output port.
// The front stage keeps pending bytes and stays ready while the group queue
// (QUEUE_DEPTH entries) has room, so it keeps taking bytes while the
// receiver stalls, until the queue fills.
// Reset (synchronous, active low) drops pending bytes and queued groups and
// clears the output valid.
module base64_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64e_in_if.sink    i_in,
    b64e_out_if.source o_out
);
    import b64e_pkg::*;

    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_group push_entry;
    t_group head_entry;

    b64e_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (head_entry),
        .i_pop   (pop)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (head_entry),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== rtl/b64e_front.sv =====
module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b64e_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output b64e_pkg::t_group o_entry
);
    import b64e_pkg::*;

    logic [15:0] r_pend;
    logic [15:0] n_pend;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        accept;
    logic        store;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign store      = !i_in.end_of_message && (r_cnt < 2'd2);
    assign o_push     = accept && !store;

    always_comb begin
        o_entry.fin = i_in.end_of_message;
        case (r_cnt)
            2'd0: begin
                o_entry.group = {i_in.data_byte, 16'h0000};
                o_entry.n_pad = 2'd2;
            end
            2'd1: begin
                o_entry.group = {r_pend[7:0], i_in.data_byte, 8'h00};
                o_entry.n_pad = 2'd1;
            end
            default: begin
                o_entry.group = {r_pend, i_in.data_byte};
                o_entry.n_pad = 2'd0;
            end
        endcase
    end

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        if (accept) begin
            if (store) begin
                n_pend = {r_pend[7:0], i_in.data_byte};
                n_cnt  = r_cnt + 2'd1;
            end else begin
                n_pend = '0;
                n_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
`include "base64_encoder_top_defines.svh"

module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_group i_data,
    output logic             o_full,
    output logic             o_valid,
    output b64e_pkg::t_group o_data,
    input  logic             i_pop
);
    import b64e_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_group        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `B64E_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, r_count < CW'(DEPTH), "push on full queue")
    `B64E_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "pop on empty queue")

endmodule

// ===== rtl/b64e_back.sv =====
`include "base64_encoder_top_defines.svh"

module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  b64e_pkg::t_group i_q_data,
    output logic             o_pop,
    b64e_out_if.source       o_out
);
    import b64e_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_out_last;
    logic       load;
    logic       pad;
    logic [5:0] sextet;
    logic [6:0] n_char;

    assign load  = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_pop = load && (r_idx == 2'd3);

    assign pad = ((r_idx == 2'd3) && (i_q_data.n_pad != 2'd0))
              || ((r_idx == 2'd2) && (i_q_data.n_pad == 2'd2));

    always_comb begin
        case (r_idx)
            2'd0:    sextet = i_q_data.group[23:18];
            2'd1:    sextet = i_q_data.group[17:12];
            2'd2:    sextet = i_q_data.group[11:6];
            default: sextet = i_q_data.group[5:0];
        endcase
        n_char = pad ? PAD_CHAR : b64_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char <= n_char;
            r_out_last <= (r_idx == 2'd3) && i_q_data.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_out_char;
    assign o_out.last_char = r_out_last;

    `B64E_ASSERT_IMPL(a_last_wraps, i_clk, i_rst_n, r_out_valid && r_out_last, r_idx == 2'd0, "last char not at group end")
    `B64E_ASSERT_IMPL(a_double_pad, i_clk, i_rst_n, r_out_valid && (r_out_char == PAD_CHAR) && !r_out_last, i_q_valid && (r_idx == 2'd3), "first pad without second")

endmodule
